### sv/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds the result and step types, the byte-class constants, the replacement
// character and the bytes-due codes. No dependencies.
package u8d_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned DUE_W  = 2;

   // Lead byte classes: mask and match pairs
   localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD2_MATCH = 8'hc0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD3_MATCH = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hf8;
   localparam logic [BYTE_W-1:0] LEAD4_MATCH = 8'hf0;

   localparam logic [CP_W-1:0]  BAD_CHAR = 21'd63;  // '?'

   localparam logic [DUE_W-1:0] DUE_NONE  = 2'd0;
   localparam logic [DUE_W-1:0] DUE_ONE   = 2'd1;
   localparam logic [DUE_W-1:0] DUE_TWO   = 2'd2;
   localparam logic [DUE_W-1:0] DUE_THREE = 2'd3;

   typedef struct packed {
      logic            char_valid;
      logic [CP_W-1:0] code_point;
      logic            end_of_string;
   } result_type;

   typedef struct packed {
      logic             has_result;
      result_type       result;
      logic [DUE_W-1:0] bytes_due;
      logic [CP_W-1:0]  partial_value;
   } step_type;

endpackage

### sv/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: input register, sequence
// state, result register and valid/stall control. Depends on u8d_pkg, u8d_step.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  req_byte_in[7:0]
//   rsp_     out  rsp_valid/rsp_stall  rsp_char_valid, rsp_code_point[20:0],
//                                      rsp_end_of_string
//
// One byte per cycle sustained while the result register is not stalled; a req
// beat passes through the input register, then is decoded into the result register.
// A byte that finishes neither a character nor the string leaves no rsp beat.
// Synchronous reset clears both valid flags and the sequence state.
// rsp_stall holds the result register; a new byte is still taken while the
// input register is free or draining in the same cycle.
module utf8_byte_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_char_valid,
   output logic [20:0] rsp_code_point,
   output logic        rsp_end_of_string
);

   logic                         in_valid_ff, in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                         out_valid_ff, out_valid_in;
   u8d_pkg::result_type          out_ff, out_in;
   logic [u8d_pkg::DUE_W-1:0]    due_ff, due_in;
   logic [u8d_pkg::CP_W-1:0]     partial_ff, partial_in;
   u8d_pkg::step_type            step;
   logic                         advance;
   logic                         req_take;

   u8d_step u_step (
      .byte_in       (in_byte_ff),
      .bytes_due     (due_ff),
      .partial_value (partial_ff),
      .step          (step)
   );

   // decode fires when the input register holds a byte and the result register is free or emptying this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      due_in       = due_ff;
      partial_in   = partial_ff;
      if (advance) begin
         out_valid_in = step.has_result;
         out_in       = step.result;
         due_in       = step.bytes_due;
         partial_in   = step.partial_value;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         due_ff       <= u8d_pkg::DUE_NONE;
         partial_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         due_ff       <= due_in;
         partial_ff   <= partial_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_valid    = out_ff.char_valid;
   assign rsp_code_point    = out_ff.code_point;
   assign rsp_end_of_string = out_ff.end_of_string;

endmodule

### sv/u8d_step.sv
// Combinational decode of one byte against the current sequence state.
// Produces the next state and the optional result beat.
// Depends on u8d_pkg.
module u8d_step (
   input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
   input  logic [u8d_pkg::DUE_W-1:0]  bytes_due,
   input  logic [u8d_pkg::CP_W-1:0]   partial_value,
   output u8d_pkg::step_type          step
);

   logic [u8d_pkg::DUE_W-1:0] due_dec;
   logic [u8d_pkg::CP_W-1:0]  cont_term;
   logic [u8d_pkg::CP_W-1:0]  merged;
   logic                      byte_zero;

   assign byte_zero = (byte_in == '0);
   assign due_dec   = bytes_due - u8d_pkg::DUE_ONE;

   // Continuation payload lands at 6 * (bytes still due after this one)
   always_comb begin
      unique case (bytes_due)
         u8d_pkg::DUE_THREE: cont_term = {3'b0, byte_in[5:0], 12'b0};
         u8d_pkg::DUE_TWO:   cont_term = {9'b0, byte_in[5:0], 6'b0};
         default:            cont_term = {15'b0, byte_in[5:0]};
      endcase
   end

   assign merged = partial_value | cont_term;

   always_comb begin
      step = '0;
      step.bytes_due     = u8d_pkg::DUE_NONE;
      step.partial_value = '0;
      if (bytes_due != u8d_pkg::DUE_NONE) begin
         priority if (byte_zero) begin
            // truncated sequence: missing bits read as zero
            step.has_result = 1'b1;
            step.result.end_of_string = 1'b1;
            if (partial_value != '0) begin
               step.result.char_valid = 1'b1;
               step.result.code_point = partial_value;
            end
         end else if (due_dec == u8d_pkg::DUE_NONE) begin
            step.has_result = 1'b1;
            if (merged == '0) begin
               step.result.end_of_string = 1'b1;
            end else begin
               step.result.char_valid = 1'b1;
               step.result.code_point = merged;
            end
         end else begin
            step.bytes_due     = due_dec;
            step.partial_value = merged;
         end
      end else begin
         priority if (byte_zero) begin
            step.has_result = 1'b1;
            step.result.end_of_string = 1'b1;
         end else if ((byte_in & u8d_pkg::ASCII_MASK) == '0) begin
            step.has_result = 1'b1;
            step.result.char_valid = 1'b1;
            step.result.code_point = {13'b0, byte_in};
         end else if ((byte_in & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_MATCH) begin
            step.bytes_due     = u8d_pkg::DUE_ONE;
            step.partial_value = {10'b0, byte_in[4:0], 6'b0};
         end else if ((byte_in & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_MATCH) begin
            step.bytes_due     = u8d_pkg::DUE_TWO;
            step.partial_value = {5'b0, byte_in[3:0], 12'b0};
         end else if ((byte_in & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_MATCH) begin
            step.bytes_due     = u8d_pkg::DUE_THREE;
            step.partial_value = {byte_in[2:0], 18'b0};
         end else begin
            step.has_result = 1'b1;
            step.result.char_valid = 1'b1;
            step.result.code_point = u8d_pkg::BAD_CHAR;
         end
      end
   end

endmodule
